// ===== rtl/tbs_pkg.sv =====
`default_nettype none

package tbs_pkg;

	localparam int RateW    = 22;
	localparam int ElapsedW = 24;
	localparam int CountW   = 15;
	localparam int LevelW   = 26;
	localparam int StoreW   = 39;
	localparam int ProdW    = ElapsedW + RateW;
	localparam int SubW     = 28;

	localparam logic [CountW-1:0] MaxChunk     = 15'd16384;
	localparam logic [StoreW-1:0] TokenScale   = 39'd8000;
	localparam logic [12:0]       TokenScaleC  = 13'd8000;
	localparam logic [StoreW-1:0] BurstFloor   = 39'd32768000;
	localparam logic [16:0]       BurstPerKbps = 17'd100000;

	// floor(x / 125) == (x * RecipM) >> 40 for any x below 2**33
	localparam logic [33:0] RecipM     = 34'd8796093023;
	localparam int          RecipShift = 40;

	localparam logic MODE_QUERY  = 1'b0;
	localparam logic MODE_COMMIT = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [ElapsedW-1:0] elapsed_us;
		logic [CountW-1:0]   byte_count;
	} in_item_t;

	typedef struct packed {
		logic [CountW-1:0] allowed_bytes;
		logic              throttled;
		logic [LevelW-1:0] token_level;
	} out_item_t;

	typedef struct packed {
		logic              mode;
		logic              bypass;
		logic              throttled;
		logic [CountW-1:0] req;
	} tbs_meta_t;

	typedef struct packed {
		tbs_meta_t         meta;
		logic [StoreW-1:0] store;
	} tbs_mid_t;

endpackage

`default_nettype wire

// ===== rtl/tbs_update.sv =====
`default_nettype none

module tbs_update (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire  [21:0]               rate_kbps,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  tbs_pkg::in_item_t         in_item,
	output logic                      mid_valid,
	input  wire                       mid_stall,
	output tbs_pkg::tbs_mid_t         mid_item
);
	import tbs_pkg::*;

	logic                v_s1;
	in_item_t            item_s1;

	logic                v_s2;
	logic                mode_s2;
	logic                bypass_s2;
	logic [CountW-1:0]   req_s2;
	logic [ProdW-1:0]    prod_s2;
	logic [StoreW-1:0]   cap_s2;
	logic [SubW-1:0]     sub_s2;

	logic [StoreW-1:0]   store_q;
	logic                mid_v_q;
	tbs_mid_t            mid_q;

	logic                rdy1, rdy2, rdy3;
	logic [ProdW-1:0]    prod_d;
	logic [StoreW-1:0]   burst_d;
	logic [StoreW-1:0]   cap_d;
	logic [SubW-1:0]     sub_d;
	logic [CountW-1:0]   req_d;
	logic [ProdW:0]      sum_d;
	logic [StoreW-1:0]   store_d;
	logic                thr_d;

	assign rdy3     = !mid_v_q || !mid_stall;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign prod_d  = ProdW'(item_s1.elapsed_us) * ProdW'(rate_kbps);
	assign burst_d = StoreW'(rate_kbps) * StoreW'(BurstPerKbps);
	assign cap_d   = (burst_d > BurstFloor) ? burst_d : BurstFloor;
	assign sub_d   = SubW'(item_s1.byte_count) * SubW'(TokenScaleC);
	assign req_d   = (item_s1.byte_count > MaxChunk) ? MaxChunk : item_s1.byte_count;

	always_comb begin
		sum_d   = (ProdW+1)'(store_q) + (ProdW+1)'(prod_s2);
		store_d = store_q;
		thr_d   = 1'b0;
		if (mode_s2 == MODE_COMMIT) begin
			store_d = (store_q > StoreW'(sub_s2)) ? store_q - StoreW'(sub_s2) : '0;
		end else if (!bypass_s2) begin
			store_d = (sum_d < (ProdW+1)'(cap_s2)) ? sum_d[StoreW-1:0] : cap_s2;
			thr_d   = (store_d < TokenScale);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			mid_v_q <= 1'b0;
			store_q <= '0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				mid_v_q <= v_s2;
			if (rdy3 && v_s2)
				store_q <= store_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid)
			item_s1 <= in_item;
		if (rdy2 && v_s1) begin
			mode_s2   <= item_s1.mode;
			bypass_s2 <= (rate_kbps == '0);
			req_s2    <= req_d;
			prod_s2   <= prod_d;
			cap_s2    <= cap_d;
			sub_s2    <= sub_d;
		end
		if (rdy3 && v_s2) begin
			mid_q.meta.mode      <= mode_s2;
			mid_q.meta.bypass    <= bypass_s2;
			mid_q.meta.throttled <= thr_d;
			mid_q.meta.req       <= req_s2;
			mid_q.store          <= store_d;
		end
	end

	assign mid_valid = mid_v_q;
	assign mid_item  = mid_q;

endmodule

`default_nettype wire

// ===== rtl/tbs_level.sv =====
`default_nettype none

module tbs_level (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       mid_valid,
	output logic                      mid_stall,
	input  tbs_pkg::tbs_mid_t         mid_item,
	output logic                      out_valid,
	input  wire                       out_stall,
	output tbs_pkg::out_item_t        out_item
);
	import tbs_pkg::*;

	logic              v_s4, v_s5, v_s6;
	tbs_meta_t         meta_s4, meta_s5;
	logic [33:0]       pp_ll_s4, pp_lh_s4;
	logic [32:0]       pp_hl_s4, pp_hh_s4;
	logic [51:0]       sum_a_s5;
	logic [50:0]       sum_b_s5;
	out_item_t         item_s6;

	logic              rdy4, rdy5, rdy6;
	logic [32:0]       x_d;
	logic [16:0]       xl_d;
	logic [15:0]       xh_d;
	logic [16:0]       ml_d, mh_d;
	logic [66:0]       total_d;
	logic [LevelW-1:0] whole_d;
	logic [CountW-1:0] allow_d;

	assign rdy6      = !v_s6 || !out_stall;
	assign rdy5      = !v_s5 || rdy6;
	assign rdy4      = !v_s4 || rdy5;
	assign mid_stall = !rdy4;

	// drop the factor 64 of 8000 first, then divide by 125
	assign x_d  = mid_item.store[StoreW-1:6];
	assign xl_d = x_d[16:0];
	assign xh_d = x_d[32:17];
	assign ml_d = RecipM[16:0];
	assign mh_d = RecipM[33:17];

	assign total_d = 67'(sum_a_s5) + 67'({sum_b_s5, 17'd0});
	assign whole_d = total_d[RecipShift+LevelW-1:RecipShift];

	always_comb begin
		if (meta_s5.mode == MODE_COMMIT)
			allow_d = '0;
		else if (meta_s5.bypass)
			allow_d = meta_s5.req;
		else if (whole_d < LevelW'(meta_s5.req))
			allow_d = whole_d[CountW-1:0];
		else
			allow_d = meta_s5.req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy4)
				v_s4 <= mid_valid;
			if (rdy5)
				v_s5 <= v_s4;
			if (rdy6)
				v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && mid_valid) begin
			meta_s4  <= mid_item.meta;
			pp_ll_s4 <= 34'(xl_d) * 34'(ml_d);
			pp_lh_s4 <= 34'(xl_d) * 34'(mh_d);
			pp_hl_s4 <= 33'(xh_d) * 33'(ml_d);
			pp_hh_s4 <= 33'(xh_d) * 33'(mh_d);
		end
		if (rdy5 && v_s4) begin
			meta_s5  <= meta_s4;
			sum_a_s5 <= 52'(pp_ll_s4) + 52'({pp_lh_s4, 17'd0});
			sum_b_s5 <= 51'(pp_hl_s4) + 51'({pp_hh_s4, 17'd0});
		end
		if (rdy6 && v_s5) begin
			item_s6.allowed_bytes <= allow_d;
			item_s6.throttled     <= meta_s5.throttled;
			item_s6.token_level   <= whole_d;
		end
	end

	assign out_valid = v_s6;
	assign out_item  = item_s6;

endmodule

`default_nettype wire

// ===== rtl/token_bucket_byte_shaper.sv =====
// channel   direction  handshake           payload
// cfg       in         cfg_we              cfg_wdata (rate_kbps)
// in        in         in_valid/in_stall   in_item   (mode, elapsed_us, byte_count)
// out       out        out_valid/out_stall out_item  (allowed_bytes, throttled, token_level)
//
// One item per cycle while out is not stalled; an item is registered in s1, s2, mid, s4, s5, s6 before out.
// The token store updates in the third stage (add and cap compare on a query, subtract on a commit).
// The level divide by 8000 runs as split partial products over three stages.
// Reset clears the rate, the token store and every stage valid.
// A stall on out fills empty stages first and reaches in_stall only when all are full.
`default_nettype none

module token_bucket_byte_shaper (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [21:0]               cfg_wdata,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  tbs_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  wire                       out_stall,
	output tbs_pkg::out_item_t        out_item
);
	import tbs_pkg::*;

	logic [RateW-1:0] rate_q;
	logic             mid_valid;
	logic             mid_stall;
	tbs_mid_t         mid_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rate_q <= '0;
		else if (cfg_we)
			rate_q <= cfg_wdata;
	end

	tbs_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.rate_kbps (rate_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.mid_valid (mid_valid),
		.mid_stall (mid_stall),
		.mid_item  (mid_item)
	);

	tbs_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_stall (mid_stall),
		.mid_item  (mid_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== rtl/tbs_checker.sv =====
`default_nettype none

module tbs_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input tbs_pkg::out_item_t  out_item
);
	import tbs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("out item changed while stalled");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("in stalled while out is free");

	a_throttle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.throttled
			|-> out_item.token_level == '0 && out_item.allowed_bytes == '0)
		else $error("throttled item reports tokens");

	a_chunk_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.allowed_bytes <= MaxChunk)
		else $error("allowance above chunk limit");

endmodule

bind token_bucket_byte_shaper tbs_checker u_tbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

// ===== test/tb_token_bucket_byte_shaper.sv =====
`default_nettype none

module tb_token_bucket_byte_shaper;
	import tbs_pkg::*;

	localparam longint unsigned UNITS_PER_BYTE = 64'd8000;
	localparam longint unsigned BURST_MIN      = 64'd32768000;
	localparam longint unsigned BURST_PER_RATE = 64'd100000;
	localparam longint unsigned CHUNK_LIMIT    = 64'd16384;
	localparam longint unsigned BUCKET_MASK    = 64'h7F_FFFF_FFFF;
	localparam logic [21:0]     RATE_MAX       = 22'h3FFFFF;
	localparam int              STUCK_LIMIT    = 5000;
	localparam int              DUE_DEPTH      = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [21:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;

	longint unsigned rate_now = 0;
	longint unsigned bucket = 0;
	out_item_t       grants_due[DUE_DEPTH];
	int              due_wr = 0;
	int              due_rd = 0;
	int              mismatches = 0;
	int              stall_left = 0;
	int              stuck_cycles = 0;
	bit              calm = 1'b0;

	token_bucket_byte_shaper DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic out_item_t shape_predict(in_item_t it);
		out_item_t       r;
		longint unsigned req;
		longint unsigned cap;
		longint unsigned sum;
		longint unsigned drain;
		longint unsigned whole;
		r = '0;
		if (it.mode == MODE_QUERY) begin
			req = (it.byte_count > CHUNK_LIMIT) ? CHUNK_LIMIT : it.byte_count;
			if (rate_now == 0) begin
				r.allowed_bytes = req[14:0];
			end else begin
				cap = rate_now * BURST_PER_RATE;
				if (cap < BURST_MIN)
					cap = BURST_MIN;
				sum = bucket + longint'(it.elapsed_us) * rate_now;
				bucket = ((sum < cap) ? sum : cap) & BUCKET_MASK;
				whole = bucket / UNITS_PER_BYTE;
				r.allowed_bytes = (whole < req) ? whole[14:0] : req[14:0];
				r.throttled = (bucket < UNITS_PER_BYTE);
			end
		end else begin
			drain = longint'(it.byte_count) * UNITS_PER_BYTE;
			bucket = (bucket > drain) ? bucket - drain : 0;
		end
		whole = bucket / UNITS_PER_BYTE;
		r.token_level = whole[25:0];
		return r;
	endfunction

	function automatic in_item_t make_item(logic mode, logic [23:0] e, logic [14:0] c);
		in_item_t it;
		it.mode = mode;
		it.elapsed_us = e;
		it.byte_count = c;
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [23:0] pick_elapsed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 24'd0;
		if (r < 50)
			return 24'($urandom_range(0, 2000));
		if (r < 80)
			return 24'($urandom_range(0, 100000));
		if (r < 95)
			return 24'($urandom_range(0, 24'hFFFFFF));
		return 24'hFFFFFF;
	endfunction

	function automatic logic [14:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 15'($urandom_range(0, 1500));
		if (r < 75)
			return 15'($urandom_range(0, 16384));
		if (r < 90)
			return 15'($urandom_range(16384, 32767));
		if (r < 95)
			return 15'd0;
		return 15'h7FFF;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_item(input in_item_t it, output out_item_t predicted);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			in_valid <= 1'b1;
		end else if (!in_valid) begin
			in_valid <= 1'b1;
		end
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = shape_predict(it);
		grants_due[due_wr % DUE_DEPTH] = predicted;
		due_wr++;
	endtask

	task automatic ask_bytes(input logic [23:0] e, input logic [14:0] c);
		out_item_t got;
		send_item(make_item(MODE_QUERY, e, c), got);
	endtask

	task automatic spend_bytes(input logic [14:0] c);
		out_item_t got;
		send_item(make_item(MODE_COMMIT, 24'($urandom_range(0, 24'hFFFFFF)), c), got);
	endtask

	task automatic set_rate(input logic [21:0] v);
		in_valid <= 1'b0;
		while (due_rd != due_wr)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_now = v;
	endtask

	task automatic test_bypass();
		ask_bytes(24'hFFFFFF, 15'd0);
		ask_bytes(24'd0, 15'd1);
		ask_bytes(24'd12345, 15'd16384);
		ask_bytes(24'hFFFFFF, 15'h7FFF);
		spend_bytes(15'd100);
	endtask

	task automatic test_refill_limits();
		set_rate(22'd1);
		ask_bytes(24'd0, 15'd10);
		ask_bytes(24'd7999, 15'd10);
		ask_bytes(24'd1, 15'd10);
		spend_bytes(15'd1);
	endtask

	task automatic test_burst_cap();
		set_rate(RATE_MAX);
		ask_bytes(24'hFFFFFF, 15'h7FFF);
		spend_bytes(15'h7FFF);
		ask_bytes(24'd0, 15'd16384);
		set_rate(22'd10);
		ask_bytes(24'd0, 15'd100);
		spend_bytes(15'd5000);
		ask_bytes(24'd0, 15'd0);
		set_rate(22'd500);
		ask_bytes(24'hFFFFFF, 15'd16384);
		spend_bytes(15'd0);
		spend_bytes(15'd1);
	endtask

	task automatic test_random_traffic(input logic [21:0] rate, input int n_items);
		int        sent;
		int        r;
		out_item_t got;
		logic [14:0] spent;
		set_rate(rate);
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_item(make_item(MODE_QUERY, pick_elapsed(), pick_count()), got);
				spent = got.allowed_bytes;
				if ($urandom_range(0, 3) == 0)
					spent = spent - 15'($urandom_range(0, spent));
				spend_bytes(spent);
				sent += 2;
			end else if (r < 80) begin
				ask_bytes(pick_elapsed(), pick_count());
				sent++;
			end else begin
				spend_bytes(pick_count());
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		int pick;
		if (!arst_n || calm) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			pick = $urandom_range(0, 99);
			out_stall <= 1'b0;
			if (pick >= 99)
				stall_left <= $urandom_range(30, 80);
			else if (pick >= 93)
				stall_left <= $urandom_range(4, 12);
			else if (pick >= 70)
				stall_left <= $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_rd == due_wr) begin
				flag_mismatch($sformatf("result with no item pending: %p", out_item));
			end else begin
				want = grants_due[due_rd % DUE_DEPTH];
				due_rd++;
				if (out_item.allowed_bytes !== want.allowed_bytes)
					flag_mismatch($sformatf("allowed_bytes %0d, want %0d",
						out_item.allowed_bytes, want.allowed_bytes));
				if (out_item.throttled !== want.throttled)
					flag_mismatch($sformatf("throttled %0b, want %0b",
						out_item.throttled, want.throttled));
				if (out_item.token_level !== want.token_level)
					flag_mismatch($sformatf("token_level %0d, want %0d",
						out_item.token_level, want.token_level));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass();
		test_refill_limits();
		test_burst_cap();
		test_random_traffic(22'd1, 125);
		test_random_traffic(22'($urandom_range(2, 64)), 125);
		calm = 1'b1;
		test_random_traffic(22'($urandom_range(65, 5000)), 125);
		calm = 1'b0;
		test_random_traffic(22'd0, 125);
		test_random_traffic(22'($urandom_range(5000, RATE_MAX)), 125);
		test_random_traffic(RATE_MAX, 125);
		test_random_traffic(22'($urandom_range(0, RATE_MAX)), 125);
		test_random_traffic(22'd327, 125);
		in_valid <= 1'b0;
		while (due_rd != due_wr)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
